@@ sv/mpd_pkg.sv @@
package mpd_pkg;

  // defaults for the top-level parameters
  localparam int DEF_MAX_SUM    = 4095;
  localparam int DEF_VALUE_BITS = 8;

  // fixed widths of the bitset words and of the item and result fields
  localparam int WORD_W   = 64;
  localparam int WORD_SH  = 6;
  localparam int VALUE_W  = 8;
  localparam int DIFF_W   = 12;
  localparam int DIFF_MAX = 4095;

  // sequencer of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_LAST,
    ST_SCAN
  } mpd_state_t;

  // passes of the bitset engine
  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_SHIFT,
    BS_SCAN,
    BS_DRAIN
  } mpd_bs_state_t;

  // commands from the sequencer to the bitset engine, one-cycle pulses
  typedef struct packed {
    logic shift_go;
    logic scan_go;
  } mpd_cmd_t;

endpackage

@@ sv/mpd_bitset.sv @@
module mpd_bitset #(
  parameter int MAX_SUM = mpd_pkg::DEF_MAX_SUM,
  localparam int SUM_W  = $clog2(MAX_SUM + 2)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mpd_pkg::mpd_cmd_t             cmd,
  input  logic [mpd_pkg::VALUE_W-1:0]   shift_value,
  input  logic [SUM_W-1:0]              half,
  output logic                          ready,
  output logic [SUM_W-1:0]              best
);
  import mpd_pkg::*;

  localparam int NWORDS  = MAX_SUM / WORD_W + 1;
  localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CW      = $clog2(NWORDS + 1);
  localparam int TOP_REM = MAX_SUM % WORD_W;
  localparam logic [WORD_W-1:0] TOP_MASK = {WORD_W{1'b1}} >> (WORD_W - 1 - TOP_REM);
  localparam logic [WORD_W-1:0] WORD_ZERO = WORD_W'(1);

  // highest set bit of a word
  function automatic logic [WORD_SH-1:0] top_bit(input logic [WORD_W-1:0] w);
    logic [WORD_SH-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) r = WORD_SH'(i);
    end
    return r;
  endfunction

  // reachable-sum bitset, one word per 64 sums
  logic [WORD_W-1:0] mem [NWORDS];
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;

  mpd_bs_state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [1:0]    ws;
  logic [WORD_SH-1:0] bs;
  logic [WORD_W-1:0]  hi;

  // data stage registers
  logic          p_write;
  logic          p_prime;
  logic          p_scan;
  logic          p_lo0;
  logic [AW-1:0] p_k;

  // issue stage signals
  logic          iss_write, iss_prime, iss_scan, iss_lo0;
  logic [AW-1:0] iss_k;
  logic [AW-1:0] addr_a, addr_b;
  logic          we;
  logic [AW-1:0] wa;
  logic [WORD_W-1:0] wd;

  logic        skip;
  logic [31:0] src_i;
  logic [31:0] n_steps;
  logic        src_neg;

  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] sh_word;
  logic [31:0]       half32;
  logic [31:0]       hw;
  logic [31:0]       pw32;
  logic [WORD_W-1:0] scan_mask;
  logic [WORD_W-1:0] hit;

  // shift pass geometry
  assign skip    = 32'(ws) >= 32'(NWORDS);
  assign n_steps = 32'(NWORDS) - 32'(ws);
  assign src_neg = (32'(cnt) + 32'(ws)) > 32'(NWORDS - 1);
  assign src_i   = 32'(NWORDS - 1) - 32'(ws) - 32'(cnt);

  // issue side and write port
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    iss_write  = 1'b0;
    iss_prime  = 1'b0;
    iss_scan   = 1'b0;
    iss_lo0    = 1'b0;
    iss_k      = '0;
    addr_a     = '0;
    addr_b     = '0;
    we         = 1'b0;
    wa         = p_k;
    wd         = sh_word;
    case (state)
      BS_CLEAR: begin
        we = 1'b1;
        wa = AW'(cnt);
        wd = (cnt == '0) ? WORD_ZERO : '0;
        if (32'(cnt) == 32'(NWORDS - 1)) begin
          state_next = BS_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      BS_IDLE: begin
        cnt_next = '0;
        if (cmd.shift_go) state_next = BS_SHIFT;
        else if (cmd.scan_go) state_next = BS_SCAN;
      end
      BS_SHIFT: begin
        if (skip) begin
          state_next = BS_IDLE;
        end else begin
          addr_b    = src_neg ? '0 : AW'(src_i);
          iss_lo0   = src_neg;
          iss_prime = (cnt == '0);
          iss_write = (cnt != '0);
          iss_k     = (cnt == '0) ? '0 : AW'(32'(NWORDS) - 32'(cnt));
          addr_a    = iss_k;
          if (32'(cnt) == n_steps) state_next = BS_DRAIN;
          else cnt_next = cnt + 1'b1;
        end
      end
      BS_SCAN: begin
        addr_a   = AW'(cnt);
        iss_k    = AW'(cnt);
        iss_scan = 1'b1;
        if (32'(cnt) == 32'(NWORDS - 1)) state_next = BS_DRAIN;
        else cnt_next = cnt + 1'b1;
      end
      BS_DRAIN: begin
        state_next = BS_IDLE;
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
    // data stage write-back
    if (p_write) begin
      we = 1'b1;
      wa = p_k;
      wd = sh_word;
    end else if (p_scan) begin
      we = 1'b1;
      wa = p_k;
      wd = (p_k == '0) ? WORD_ZERO : '0;
    end
  end

  // shifted word: old word or'd with the source pair shifted up by bs
  always_comb begin
    lo      = p_lo0 ? '0 : rd_b;
    sh_word = rd_a | (hi << bs);
    if (bs != '0) sh_word = sh_word | (lo >> (7'(WORD_W) - 7'(bs)));
    if (p_k == AW'(NWORDS - 1)) sh_word = sh_word & TOP_MASK;
  end

  // reachable sums not above half the total in the word being scanned
  always_comb begin
    half32 = 32'(half);
    hw     = half32 >> WORD_SH;
    pw32   = 32'(p_k);
    if (pw32 < hw) scan_mask = {WORD_W{1'b1}};
    else if (pw32 == hw) scan_mask = {WORD_W{1'b1}} >> (6'd63 - half32[WORD_SH-1:0]);
    else scan_mask = '0;
    hit = rd_a & scan_mask;
  end

  // memory ports
  always_ff @(posedge clk) begin
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
    if (we) mem[wa] <= wd;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BS_CLEAR;
      cnt     <= '0;
      p_write <= 1'b0;
      p_prime <= 1'b0;
      p_scan  <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      p_write <= iss_write;
      p_prime <= iss_prime;
      p_scan  <= iss_scan;
    end
  end

  // payload of the passes
  always_ff @(posedge clk) begin
    p_k   <= iss_k;
    p_lo0 <= iss_lo0;
    if (state == BS_IDLE && cmd.shift_go) begin
      ws <= shift_value[VALUE_W-1:WORD_SH];
      bs <= shift_value[WORD_SH-1:0];
    end
    if (p_write || p_prime) hi <= rd_b;
    if (state == BS_IDLE && cmd.scan_go) begin
      best <= '0;
    end else if (p_scan && (hit != '0)) begin
      best <= SUM_W'((pw32 << WORD_SH) | 32'(top_bit(hit)));
    end
  end

  assign ready = (state == BS_IDLE);

endmodule

@@ sv/min_partition_difference.sv @@
// Minimum partition difference. Values arrive one item at a time, the last
// item of each set flagged by is_last; on that item one result gives the
// smallest difference between the sums of two halves of the set, saturated
// at 4095, with sum_overflow set (and the difference at 4095) when the set
// total went above MAX_SUM. Reachable subset sums live in a memory of
// NWORDS = MAX_SUM/64 + 1 words of 64 bits with one write and two read
// ports. Each item rewrites the upper words in one read-modify-write pass;
// the last item adds a scan of every word, which also puts the memory back
// to its empty state. After reset the block clears every word of the
// memory before it takes its first item. A finished result waits in an
// output register while the next set streams in.
module min_partition_difference #(
  parameter int MAX_SUM    = mpd_pkg::DEF_MAX_SUM,
  parameter int VALUE_BITS = mpd_pkg::DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mpd_pkg::VALUE_W-1:0]  item_value,
  input  logic                         is_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mpd_pkg::DIFF_W-1:0]   min_difference,
  output logic                         sum_overflow
);
  import mpd_pkg::*;

  localparam int SUM_W = $clog2(MAX_SUM + 2);
  localparam int VW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

  mpd_state_t state, state_next;
  mpd_cmd_t   cmd;
  logic       bs_ready;
  logic [SUM_W-1:0] best;
  logic [SUM_W-1:0] half;

  logic [SUM_W-1:0] total;
  logic             ovf;
  logic             last_r;
  logic             accept;
  logic             load_out;

  logic [VW-1:0]      v;
  logic [VALUE_W-1:0] v8;
  logic [31:0]        sum32;
  logic [31:0]        diff32;
  logic [DIFF_W-1:0]  diff;

  // item value limited to its valid bits
  assign v  = item_value[VW-1:0];
  assign v8 = VALUE_W'(v);

  // running total and final difference
  assign sum32  = 32'(total) + 32'(v8);
  assign half   = total >> 1;
  assign diff32 = 32'(total) - (32'(best) << 1);
  assign diff   = (ovf || diff32 > 32'(DIFF_MAX)) ? DIFF_W'(DIFF_MAX) : DIFF_W'(diff32);

  assign in_stall = !(state == ST_IDLE && bs_ready);
  assign accept   = in_valid && !in_stall;

  mpd_bitset #(
    .MAX_SUM (MAX_SUM)
  ) u_bitset (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .shift_value (v8),
    .half        (half),
    .ready       (bs_ready),
    .best        (best)
  );

  // sequencer: shift pass per item, scan pass after the last one
  always_comb begin
    state_next   = state;
    cmd.shift_go = 1'b0;
    cmd.scan_go  = 1'b0;
    load_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.shift_go = 1'b1;
          state_next   = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (bs_ready) state_next = last_r ? ST_LAST : ST_IDLE;
      end
      ST_LAST: begin
        if (!out_valid) begin
          cmd.scan_go = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (bs_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      total     <= '0;
      ovf       <= 1'b0;
      last_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // accumulate, holding at one above the largest sum
      if (accept) begin
        last_r <= is_last;
        if (sum32 > 32'(MAX_SUM)) begin
          total <= SUM_W'(MAX_SUM + 1);
          ovf   <= 1'b1;
        end else begin
          total <= SUM_W'(sum32);
        end
      end else if (load_out) begin
        total <= '0;
        ovf   <= 1'b0;
      end
      // output register
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      min_difference <= diff;
      sum_overflow   <= ovf;
    end
  end

  // a result is only loaded into an empty output register
  assert property (@(posedge clk) disable iff (rst) load_out |-> !out_valid)
    else $error("result loaded over a pending one");

  // an overflowed set always reports the saturated difference
  assert property (@(posedge clk) disable iff (rst)
    out_valid && sum_overflow |-> min_difference == DIFF_W'(DIFF_MAX))
    else $error("overflow without saturated difference");

  // the running total never passes its saturation point
  assert property (@(posedge clk) disable iff (rst) 32'(total) <= 32'(MAX_SUM + 1))
    else $error("running total beyond saturation");

  // total minus twice a subset sum keeps the parity of the total
  assert property (@(posedge clk) disable iff (rst)
    load_out && !ovf |-> diff32[0] == total[0])
    else $error("difference parity differs from total");

endmodule
